// File: rtl/core/cooccurrence_edge_table_defines.svh
// Assertion macros for the co-occurrence edge table.
// No dependencies; the asserting modules need clk and rst in scope.
`ifndef COOCCURRENCE_EDGE_TABLE_DEFINES_SVH
`define COOCCURRENCE_EDGE_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CE_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge table check failed");

// next-cycle implication, checked outside reset
`define CE_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge table sequencing check failed");

`endif

// File: rtl/core/ce_pkg.sv
// Shared types and constants for the co-occurrence edge table.
// No dependencies.
package ce_pkg;

  localparam int HIT_DEPTH_DEF  = 256;
  localparam int EDGE_DEPTH_DEF = 2048;
  localparam int ID_BITS_DEF    = 16;
  localparam int KIND_BITS      = 4;
  localparam int WEIGHT_BITS    = 16;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 16'hFFFF;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_BUILD  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RDATA, S_RDI, S_LATI, S_RDJ, S_LATJ, S_SADDR, S_SCMP, S_APPEND, S_NEXT
  } seq_state_t;

endpackage

// File: rtl/core/ce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/ce_match.sv
// Shared pair compare and saturating weight increment.
// Depends on ce_pkg.
module ce_match #(
  parameter int ID_BITS = ce_pkg::ID_BITS_DEF
) (
  input  logic [ID_BITS-1:0]             x,
  input  logic [ID_BITS-1:0]             y,
  input  logic [ID_BITS-1:0]             a_id,
  input  logic [ID_BITS-1:0]             b_id,
  input  logic [ce_pkg::WEIGHT_BITS-1:0] count,
  output logic                           hit,
  output logic [ce_pkg::WEIGHT_BITS-1:0] count_inc
);
  import ce_pkg::*;

  // either direction matches, classes ignored
  assign hit = ((a_id == x) && (b_id == y)) || ((a_id == y) && (b_id == x));
  assign count_inc = (count == WEIGHT_MAX) ? count : count + 1'b1;
endmodule

// File: rtl/core/cooccurrence_edge_table.sv
// Co-occurrence edge table: hit buffer, pair walker and edge store.
// Append, out-of-range read and unused code strobe done from idle; an in-range read passes S_RDATA first.
// Append may follow every cycle; an in-range read holds busy while in S_RDATA.
// Build: per pair of hits, reads both, skips equal ids, scans stored edges, bumps a match or appends.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (rst, synchronous) empties hit buffer and table; RAM contents are not cleared.
module cooccurrence_edge_table #(
  parameter int HIT_DEPTH  = ce_pkg::HIT_DEPTH_DEF,
  parameter int EDGE_DEPTH = ce_pkg::EDGE_DEPTH_DEF,
  parameter int ID_BITS    = ce_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] entity_id,
  input  logic [3:0]  entity_kind,
  input  logic [10:0] edge_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] edge_total,
  output logic [15:0] from_entity,
  output logic [3:0]  from_kind,
  output logic [15:0] to_entity,
  output logic [3:0]  to_kind,
  output logic [15:0] edge_weight
);
  import ce_pkg::*;
  `include "cooccurrence_edge_table_defines.svh"

  localparam int HA = $clog2(HIT_DEPTH);
  localparam int HC = $clog2(HIT_DEPTH + 1);
  localparam int EA = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int SC = $clog2(EDGE_DEPTH + 1);
  localparam int HW = ID_BITS + KIND_BITS;
  localparam int EW = 2 * HW + WEIGHT_BITS;

  seq_state_t state, state_next;

  // counters and pair indexes
  logic [HC-1:0] hit_cnt, i, j;
  logic [SC-1:0] stored, e;
  // latched endpoints of the current pair
  logic [ID_BITS-1:0]   x, y;
  logic [KIND_BITS-1:0] kx, ky;

  // RAM ports
  logic          hwe;
  logic [HA-1:0] hraddr;
  logic [HW-1:0] hrdata;
  logic          ewe;
  logic [EA-1:0] ewaddr, eraddr;
  logic [EW-1:0] ewdata, erdata;

  // stored edge fields
  logic [ID_BITS-1:0]     ra_id, rb_id;
  logic [KIND_BITS-1:0]   ra_kind, rb_kind;
  logic [WEIGHT_BITS-1:0] r_count, count_inc;
  logic                   pair_hit;

  // input resizing
  logic [ID_BITS+15:0] id_ext;
  logic [ID_BITS-1:0]  in_id;
  logic [EA+10:0]      idx_ext;
  logic [EA-1:0]       idx_addr;
  logic                idx_ok, hit_room, edge_room;
  logic                accept;
  logic                more_j, more_i;

  assign id_ext   = {{ID_BITS{1'b0}}, entity_id};
  assign in_id    = id_ext[ID_BITS-1:0];
  assign idx_ext  = {{EA{1'b0}}, edge_index};
  assign idx_addr = idx_ext[EA-1:0];
  assign idx_ok   = {{SC{1'b0}}, edge_index} < {11'd0, stored};
  assign hit_room = hit_cnt < HC'(HIT_DEPTH);
  assign edge_room = stored < SC'(EDGE_DEPTH);
  assign accept   = start && !busy;
  assign more_j   = ({1'b0, j} + 1'b1) < {1'b0, hit_cnt};
  assign more_i   = ({1'b0, i} + 2'd2) < {1'b0, hit_cnt};

  assign {ra_id, ra_kind, rb_id, rb_kind, r_count} = erdata;

  ce_ram #(.WIDTH(HW), .DEPTH(HIT_DEPTH)) u_hits (
    .clk(clk), .we(hwe), .waddr(hit_cnt[HA-1:0]), .wdata({in_id, entity_kind}),
    .raddr(hraddr), .rdata(hrdata)
  );

  ce_ram #(.WIDTH(EW), .DEPTH(EDGE_DEPTH)) u_edges (
    .clk(clk), .we(ewe), .waddr(ewaddr), .wdata(ewdata),
    .raddr(eraddr), .rdata(erdata)
  );

  ce_match #(.ID_BITS(ID_BITS)) u_match (
    .x(x), .y(y), .a_id(ra_id), .b_id(rb_id), .count(r_count),
    .hit(pair_hit), .count_inc(count_inc)
  );

  assign busy = (state != S_IDLE);

  // stored count onto the 12-bit total port
  logic [SC+11:0] total_ext;
  assign total_ext  = {12'd0, stored};
  assign edge_total = total_ext[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    hwe        = 1'b0;
    hraddr     = i[HA-1:0];
    ewe        = 1'b0;
    ewaddr     = e[EA-1:0];
    ewdata     = {x, kx, y, ky, WEIGHT_BITS'(1)};
    eraddr     = e[EA-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_APPEND: hwe = hit_room;
            ACT_BUILD: begin
              if (hit_cnt > HC'(1)) state_next = S_RDI;
            end
            ACT_READ: begin
              eraddr = idx_addr;
              if (idx_ok) state_next = S_RDATA;
            end
            default: ;
          endcase
        end
      end
      S_RDATA: state_next = S_IDLE;
      S_RDI: begin
        hraddr     = i[HA-1:0];
        state_next = S_LATI;
      end
      S_LATI: state_next = S_RDJ;
      S_RDJ: begin
        hraddr     = j[HA-1:0];
        state_next = S_LATJ;
      end
      S_LATJ: begin
        if (hrdata[HW-1:KIND_BITS] == x) state_next = S_NEXT;
        else if (stored == '0)           state_next = S_APPEND;
        else                             state_next = S_SADDR;
      end
      S_SADDR: state_next = S_SCMP;
      S_SCMP: begin
        if (pair_hit) begin
          ewe        = 1'b1;
          ewdata     = {ra_id, ra_kind, rb_id, rb_kind, count_inc};
          state_next = S_NEXT;
        end else if (({1'b0, e} + 1'b1) < {1'b0, stored}) begin
          state_next = S_SADDR;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        ewaddr     = stored[EA-1:0];
        ewe        = edge_room;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (more_j || more_i) state_next = more_j ? S_RDJ : S_RDI;
        else                  state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result payload helper: endpoint ids onto 16-bit ports
  logic [ID_BITS+15:0] a_ext, b_ext;
  assign a_ext = {16'd0, ra_id};
  assign b_ext = {16'd0, rb_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt <= '0;
      stored  <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status      <= ST_OK;
            from_entity <= '0;
            from_kind   <= '0;
            to_entity   <= '0;
            to_kind     <= '0;
            edge_weight <= '0;
            i           <= '0;
            j           <= HC'(1);
            case (action)
              ACT_APPEND: begin
                done <= 1'b1;
                if (hit_room) hit_cnt <= hit_cnt + 1'b1;
                else          status  <= ST_FULL;
              end
              ACT_BUILD: begin
                stored <= '0;
                if (hit_cnt <= HC'(1)) begin
                  hit_cnt <= '0;
                  done    <= 1'b1;
                end
              end
              ACT_READ: begin
                if (!idx_ok) begin
                  status <= ST_RANGE;
                  done   <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_RDATA: begin
          from_entity <= a_ext[15:0];
          from_kind   <= ra_kind;
          to_entity   <= b_ext[15:0];
          to_kind     <= rb_kind;
          edge_weight <= r_count;
          done        <= 1'b1;
        end
        S_LATI: begin
          x  <= hrdata[HW-1:KIND_BITS];
          kx <= hrdata[KIND_BITS-1:0];
        end
        S_LATJ: begin
          y  <= hrdata[HW-1:KIND_BITS];
          ky <= hrdata[KIND_BITS-1:0];
          e  <= '0;
        end
        S_SCMP: e <= e + 1'b1;
        S_APPEND: begin
          if (edge_room) stored <= stored + 1'b1;
        end
        S_NEXT: begin
          if (more_j) begin
            j <= j + 1'b1;
          end else if (more_i) begin
            i <= i + 1'b1;
            j <= i + HC'(2);
          end else begin
            hit_cnt <= '0;
            done    <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `CE_IMPLY(a_stored_cap, 1'b1, stored <= SC'(EDGE_DEPTH))
  `CE_IMPLY(a_hit_cap, 1'b1, hit_cnt <= HC'(HIT_DEPTH))
  `CE_IMPLY(a_ewe_state, ewe, (state == S_SCMP) || (state == S_APPEND))
  `CE_NEXT(a_build_busy, accept && (action == ACT_BUILD) && (hit_cnt > HC'(1)), busy)
endmodule
